/* rtl/bsc_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants for the banker's safety checker
// no dependencies

package bsc_pkg;

    localparam int PROCESSES = 8;
    localparam int RESOURCES = 4;
    localparam int PROC_W    = $clog2(PROCESSES);
    localparam int RES_W     = $clog2(RESOURCES);
    localparam int CNT_W     = $clog2(PROCESSES + 1);
    localparam int ISS_W     = $clog2(RESOURCES + 1);
    localparam int ADDR_W    = PROC_W + RES_W;
    localparam int DEPTH     = PROCESSES * RESOURCES;
    localparam int VAL_W     = 8;
    localparam int WORK_W    = 12;

    typedef enum logic [2:0] {
        ACT_LOAD      = 3'd0,
        ACT_SET_AVAIL = 3'd1,
        ACT_STAGE     = 3'd2,
        ACT_CHECK     = 3'd3,
        ACT_GRANT     = 3'd4
    } action_t;

    typedef enum logic [2:0] {
        STS_ACCEPTED    = 3'd0,
        STS_SAFE        = 3'd1,
        STS_UNSAFE      = 3'd2,
        STS_OVER_NEED   = 3'd3,
        STS_OVER_AVAIL  = 3'd4,
        STS_GRANTED     = 3'd5,
        STS_ROLLED_BACK = 3'd6,
        STS_BAD_LOAD    = 3'd7
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RESULT,
        ST_ROW_RD,
        ST_G_DECIDE,
        ST_G_COMMIT,
        ST_SC_INIT,
        ST_SC_PROC,
        ST_SC_EVAL,
        ST_EMIT,
        ST_ROLLBACK
    } state_t;

    // one table entry: remaining need and units held
    typedef struct packed {
        logic [VAL_W-1:0] need;
        logic [VAL_W-1:0] held;
    } entry_t;

    typedef logic [WORK_W-1:0] work_t;

endpackage

/* rtl/bankers_safety_checker_top.sv */
`timescale 1ns / 1ps
// banker's algorithm allocator with safety check, table kept in one synchronous ram
// depends on bsc_pkg
//
// channel  dir  signals                      content
// s_*      in   tvalid tready tdata tuser    command word
// m_*      out  tvalid tready tdata tuser    result word, tlast on final result
//
// load, set available and stage request: result goes through the result state into the output register
// safety scan: each unfinished process has its row read lane by lane, a finished one is skipped,
//   up to PROCESSES passes; the single table read port reads one lane at a time
// grant: row read and decide, one commit write per lane, a scan, rollback writes if unsafe
// reset clears all control state and the per-entry valid bits, no clearing pass
// a new word is taken only in idle; a stalled result holds the sequencer

module bankers_safety_checker_top
    import bsc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // process_index[2:0], resource_index[4:3], max_value[12:5], held_value[20:13],
    // amount[28:21], zero fill [31:29]
    input  logic [31:0] s_tdata,
    // action[2:0]
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // seq_process[2:0], zero fill [7:3]
    output logic [7:0]  m_tdata,
    // status[2:0]
    output logic [2:0]  m_tuser,
    output logic        m_tlast
);

    state_t state_reg, state_next;

    // input fields
    action_t            in_action;
    logic [PROC_W-1:0]  in_proc;
    logic [RES_W-1:0]   in_res;
    logic [VAL_W-1:0]   in_max;
    logic [VAL_W-1:0]   in_held;
    logic [VAL_W-1:0]   in_amt;
    logic               in_fire;

    assign in_action = action_t'(s_tuser);
    assign in_proc   = s_tdata[2:0];
    assign in_res    = s_tdata[4:3];
    assign in_max    = s_tdata[12:5];
    assign in_held   = s_tdata[20:13];
    assign in_amt    = s_tdata[28:21];
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_fire   = s_tvalid && s_tready;

    // table memory
    entry_t             mem [DEPTH];
    logic [DEPTH-1:0]   ent_valid_reg;
    logic               mem_we, mem_re;
    logic [ADDR_W-1:0]  waddr, raddr;
    entry_t             wdata;
    entry_t             rd_data_reg;
    logic               rd_ok_reg;
    entry_t             rd_entry;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[waddr] <= wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[raddr];
            rd_ok_reg   <= ent_valid_reg[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_valid_reg <= '0;
        end
        else if (mem_we)
        begin
            ent_valid_reg[waddr] <= 1'b1;
        end
    end

    // an entry never written reads as zero
    assign rd_entry = rd_ok_reg ? rd_data_reg : '0;

    // datapath registers
    logic [VAL_W-1:0]   avail_reg [RESOURCES], avail_next [RESOURCES];
    logic [VAL_W-1:0]   req_reg [RESOURCES], req_next [RESOURCES];
    work_t              work_reg [RESOURCES], work_next [RESOURCES];
    logic [VAL_W-1:0]   row_need_reg [RESOURCES], row_need_next [RESOURCES];
    logic [VAL_W-1:0]   row_held_reg [RESOURCES], row_held_next [RESOURCES];
    logic [VAL_W-1:0]   orig_need_reg [RESOURCES], orig_need_next [RESOURCES];
    logic [VAL_W-1:0]   orig_held_reg [RESOURCES], orig_held_next [RESOURCES];
    logic [PROC_W-1:0]  seq_reg [PROCESSES], seq_next [PROCESSES];
    logic [PROCESSES-1:0] finished_reg, finished_next;
    logic [PROC_W-1:0]  row_p_reg, row_p_next;
    logic [PROC_W-1:0]  grant_p_reg, grant_p_next;
    logic               is_grant_reg, is_grant_next;
    logic               scanning_reg, scanning_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               found_reg, found_next;
    logic [ISS_W-1:0]   iss_reg, iss_next;
    logic               pend_reg, pend_next;
    logic [RES_W-1:0]   pend_r_reg, pend_r_next;
    logic [PROC_W-1:0]  emit_idx_reg, emit_idx_next;
    status_t            res_status_reg, res_status_next;

    // output register
    logic               out_valid_reg;
    status_t            out_status_reg;
    logic [PROC_W-1:0]  out_proc_reg;
    logic               out_last_reg;
    logic               out_load;
    status_t            out_status;
    logic [PROC_W-1:0]  out_proc;
    logic               out_last;
    logic               slot_free;

    assign slot_free = !out_valid_reg || m_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tuser   = out_status_reg;
    assign m_tdata   = {{(8 - PROC_W){1'b0}}, out_proc_reg};
    assign m_tlast   = out_last_reg;

    // lane compares over the row buffer
    logic               fits_all, over_need, over_avail;
    work_t              new_work [RESOURCES];
    logic [WORK_W:0]    sum_w [RESOURCES];

    always_comb
    begin
        fits_all   = 1'b1;
        over_need  = 1'b0;
        over_avail = 1'b0;
        for (int r = 0; r < RESOURCES; r++)
        begin
            if ({{(WORK_W - VAL_W){1'b0}}, row_need_reg[r]} > work_reg[r])
            begin
                fits_all = 1'b0;
            end
            if (req_reg[r] > row_need_reg[r])
            begin
                over_need = 1'b1;
            end
            if (req_reg[r] > avail_reg[r])
            begin
                over_avail = 1'b1;
            end
            sum_w[r]    = {1'b0, work_reg[r]} + {{(WORK_W + 1 - VAL_W){1'b0}}, row_held_reg[r]};
            new_work[r] = sum_w[r][WORK_W] ? {WORK_W{1'b1}} : sum_w[r][WORK_W-1:0];
        end
    end

    // scan progress
    logic fin_now, last_p, scan_safe, scan_unsafe, last_lane;

    assign fin_now     = (state_reg == ST_SC_EVAL) && fits_all;
    assign last_p      = (row_p_reg == PROC_W'(PROCESSES - 1));
    assign scan_safe   = fin_now && (count_reg == CNT_W'(PROCESSES - 1));
    assign scan_unsafe = !scan_safe && last_p && !(found_reg || fin_now);
    assign last_lane   = (iss_reg[RES_W-1:0] == RES_W'(RESOURCES - 1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (in_action)
                        ACT_LOAD, ACT_SET_AVAIL, ACT_STAGE: state_next = ST_RESULT;
                        ACT_CHECK:                          state_next = ST_SC_INIT;
                        ACT_GRANT:                          state_next = ST_ROW_RD;
                        default:                            state_next = ST_IDLE;
                    endcase
                end
            end
            ST_RESULT:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_ROW_RD:
            begin
                if (iss_reg == ISS_W'(RESOURCES) && !pend_reg)
                begin
                    state_next = scanning_reg ? ST_SC_EVAL : ST_G_DECIDE;
                end
            end
            ST_G_DECIDE:
            begin
                state_next = (over_need || over_avail) ? ST_RESULT : ST_G_COMMIT;
            end
            ST_G_COMMIT:
            begin
                if (last_lane)
                begin
                    state_next = ST_SC_INIT;
                end
            end
            ST_SC_INIT:
            begin
                state_next = ST_SC_PROC;
            end
            ST_SC_PROC, ST_SC_EVAL:
            begin
                if (state_reg == ST_SC_PROC && !finished_reg[row_p_reg])
                begin
                    state_next = ST_ROW_RD;
                end
                else if (scan_safe)
                begin
                    state_next = is_grant_reg ? ST_RESULT : ST_EMIT;
                end
                else if (scan_unsafe)
                begin
                    state_next = is_grant_reg ? ST_ROLLBACK : ST_RESULT;
                end
                else
                begin
                    state_next = ST_SC_PROC;
                end
            end
            ST_EMIT:
            begin
                if (slot_free && emit_idx_reg == PROC_W'(PROCESSES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_ROLLBACK:
            begin
                if (last_lane)
                begin
                    state_next = ST_RESULT;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        avail_next      = avail_reg;
        req_next        = req_reg;
        work_next       = work_reg;
        row_need_next   = row_need_reg;
        row_held_next   = row_held_reg;
        orig_need_next  = orig_need_reg;
        orig_held_next  = orig_held_reg;
        seq_next        = seq_reg;
        finished_next   = finished_reg;
        row_p_next      = row_p_reg;
        grant_p_next    = grant_p_reg;
        is_grant_next   = is_grant_reg;
        scanning_next   = scanning_reg;
        count_next      = count_reg;
        found_next      = found_reg;
        iss_next        = iss_reg;
        pend_next       = pend_reg;
        pend_r_next     = pend_r_reg;
        emit_idx_next   = emit_idx_reg;
        res_status_next = res_status_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        waddr           = {grant_p_reg, iss_reg[RES_W-1:0]};
        raddr           = {row_p_reg, iss_reg[RES_W-1:0]};
        wdata           = '0;
        out_load        = 1'b0;
        out_status      = res_status_reg;
        out_proc        = '0;
        out_last        = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    scanning_next   = 1'b0;
                    res_status_next = STS_ACCEPTED;
                    unique case (in_action)
                        ACT_LOAD:
                        begin
                            if (in_held > in_max)
                            begin
                                res_status_next = STS_BAD_LOAD;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                waddr      = {in_proc, in_res};
                                wdata.need = in_max - in_held;
                                wdata.held = in_held;
                            end
                        end
                        ACT_SET_AVAIL: avail_next[in_res] = in_amt;
                        ACT_STAGE:     req_next[in_res]   = in_amt;
                        ACT_CHECK:     is_grant_next      = 1'b0;
                        ACT_GRANT:
                        begin
                            is_grant_next = 1'b1;
                            grant_p_next  = in_proc;
                            row_p_next    = in_proc;
                            iss_next      = '0;
                            pend_next     = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_RESULT:
            begin
                out_load = slot_free;
            end
            ST_ROW_RD:
            begin
                // read lane iss, capture lane read in the previous cycle
                if (iss_reg < ISS_W'(RESOURCES))
                begin
                    mem_re      = 1'b1;
                    iss_next    = iss_reg + 1'b1;
                    pend_next   = 1'b1;
                    pend_r_next = iss_reg[RES_W-1:0];
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (pend_reg)
                begin
                    row_need_next[pend_r_reg] = rd_entry.need;
                    row_held_next[pend_r_reg] = rd_entry.held;
                end
            end
            ST_G_DECIDE:
            begin
                if (over_need)
                begin
                    res_status_next = STS_OVER_NEED;
                end
                else if (over_avail)
                begin
                    res_status_next = STS_OVER_AVAIL;
                end
                else
                begin
                    orig_need_next = row_need_reg;
                    orig_held_next = row_held_reg;
                    iss_next       = '0;
                    for (int r = 0; r < RESOURCES; r++)
                    begin
                        avail_next[r] = avail_reg[r] - req_reg[r];
                    end
                end
            end
            ST_G_COMMIT:
            begin
                mem_we     = 1'b1;
                wdata.need = orig_need_reg[iss_reg[RES_W-1:0]] - req_reg[iss_reg[RES_W-1:0]];
                wdata.held = orig_held_reg[iss_reg[RES_W-1:0]] + req_reg[iss_reg[RES_W-1:0]];
                iss_next   = iss_reg + 1'b1;
            end
            ST_SC_INIT:
            begin
                for (int r = 0; r < RESOURCES; r++)
                begin
                    work_next[r] = {{(WORK_W - VAL_W){1'b0}}, avail_reg[r]};
                end
                finished_next = '0;
                count_next    = '0;
                found_next    = 1'b0;
                row_p_next    = '0;
                scanning_next = 1'b1;
            end
            ST_SC_PROC, ST_SC_EVAL:
            begin
                if (state_reg == ST_SC_PROC && !finished_reg[row_p_reg])
                begin
                    iss_next  = '0;
                    pend_next = 1'b0;
                end
                else
                begin
                    if (fin_now)
                    begin
                        work_next                         = new_work;
                        seq_next[count_reg[PROC_W-1:0]]   = row_p_reg;
                        finished_next[row_p_reg]          = 1'b1;
                        count_next                        = count_reg + 1'b1;
                        found_next                        = 1'b1;
                    end
                    if (scan_safe)
                    begin
                        emit_idx_next   = '0;
                        res_status_next = STS_GRANTED;
                    end
                    else if (scan_unsafe)
                    begin
                        iss_next        = '0;
                        res_status_next = STS_UNSAFE;
                    end
                    else if (last_p)
                    begin
                        // start another pass
                        row_p_next = '0;
                        found_next = 1'b0;
                    end
                    else
                    begin
                        row_p_next = row_p_reg + 1'b1;
                    end
                end
            end
            ST_EMIT:
            begin
                out_status = STS_SAFE;
                out_proc   = seq_reg[emit_idx_reg];
                out_last   = (emit_idx_reg == PROC_W'(PROCESSES - 1));
                if (slot_free)
                begin
                    out_load      = 1'b1;
                    emit_idx_next = emit_idx_reg + 1'b1;
                end
            end
            ST_ROLLBACK:
            begin
                mem_we     = 1'b1;
                wdata.need = orig_need_reg[iss_reg[RES_W-1:0]];
                wdata.held = orig_held_reg[iss_reg[RES_W-1:0]];
                iss_next   = iss_reg + 1'b1;
                if (last_lane)
                begin
                    res_status_next = STS_ROLLED_BACK;
                    for (int r = 0; r < RESOURCES; r++)
                    begin
                        avail_next[r] = avail_reg[r] + req_reg[r];
                    end
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            avail_reg     <= '{default: '0};
            req_reg       <= '{default: '0};
            work_reg      <= '{default: '0};
            finished_reg  <= '0;
            is_grant_reg  <= 1'b0;
            scanning_reg  <= 1'b0;
            count_reg     <= '0;
            found_reg     <= 1'b0;
            iss_reg       <= '0;
            pend_reg      <= 1'b0;
            emit_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            avail_reg    <= avail_next;
            req_reg      <= req_next;
            work_reg     <= work_next;
            finished_reg <= finished_next;
            is_grant_reg <= is_grant_next;
            scanning_reg <= scanning_next;
            count_reg    <= count_next;
            found_reg    <= found_next;
            iss_reg      <= iss_next;
            pend_reg     <= pend_next;
            emit_idx_reg <= emit_idx_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        row_need_reg   <= row_need_next;
        row_held_reg   <= row_held_next;
        orig_need_reg  <= orig_need_next;
        orig_held_reg  <= orig_held_next;
        seq_reg        <= seq_next;
        row_p_reg      <= row_p_next;
        grant_p_reg    <= grant_p_next;
        pend_r_reg     <= pend_r_next;
        res_status_reg <= res_status_next;
        if (out_load)
        begin
            out_status_reg <= out_status;
            out_proc_reg   <= out_proc;
            out_last_reg   <= out_last;
        end
    end

    // finished flags and finish count move together
    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(finished_reg) == int'(count_reg))
        else $error("finished flags disagree with finish count");

    // sequencer never reads and writes the table in one cycle
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("table read and write overlap");

    // a read in flight only exists inside the row read
    a_pend_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (state_reg == ST_ROW_RD))
        else $error("pending table read outside row read");

    // commit only after the need check passed
    a_commit_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_G_COMMIT) |-> !over_need)
        else $error("grant committed above need");

    // a new result is loaded only into a free output slot
    a_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> slot_free)
        else $error("result loaded over a waiting word");

endmodule
